// ===== sv/set_assoc_cache_nru_top_defines.svh =====
// Assertion macros for the set-associative NRU cache tag block
`ifndef SET_ASSOC_CACHE_NRU_TOP_DEFINES_SVH
`define SET_ASSOC_CACHE_NRU_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define SAC_NRU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define SAC_NRU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sac_nru_pkg.sv =====
// Package: shared types and constants of the set-associative NRU cache tag block
`default_nettype none
package sac_nru_pkg;

  localparam int unsigned AB_W       = 6;
  localparam int unsigned OB_W       = 5;
  localparam int unsigned IB_W       = 4;
  localparam int unsigned WU_W       = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 6;
  localparam int unsigned SH_W       = OB_W + 1;
  localparam int unsigned NW_W       = WU_W + 1;
  localparam int unsigned IDX_W      = (2 ** IB_W) - 1;
  localparam int unsigned REM_W      = IDX_W + 2;
  localparam int unsigned STEP_W     = 4;
  localparam int unsigned WAY_OUT_W  = 3;
  localparam int unsigned MISS_W     = 32;

  localparam logic [AB_W-1:0] AB_RESET = AB_W'(32);
  localparam logic [OB_W-1:0] OB_RESET = OB_W'(4);
  localparam logic [IB_W-1:0] IB_RESET = IB_W'(10);
  localparam logic [WU_W-1:0] WU_RESET = WU_W'(8);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ADDR_LEN,
    CFG_OFS_LEN,
    CFG_IDX_LEN,
    CFG_WAYS_IN_USE
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_REDUCE,
    S_READ,
    S_UPDATE
  } state_t;

endpackage
`default_nettype wire

// ===== sv/sac_nru_in_if.sv =====
// Interface: address input channel
`default_nettype none
interface sac_nru_in_if #(
  parameter int unsigned ADDR_WIDTH = 32
) ();
  logic                  valid;
  logic                  ready;
  logic [ADDR_WIDTH-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface
`default_nettype wire

// ===== sv/sac_nru_out_if.sv =====
// Interface: lookup result output channel
`default_nettype none
interface sac_nru_out_if import sac_nru_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [WAY_OUT_W-1:0] way;
  logic [MISS_W-1:0]    misses_so_far;

  modport source (output valid, output hit, output way, output misses_so_far, input ready);
  modport sink   (input valid, input hit, input way, input misses_so_far, output ready);
endinterface
`default_nettype wire

// ===== sv/sac_nru_ram.sv =====
// Generic single-port-write, registered-read RAM
`default_nettype none
module sac_nru_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/set_assoc_cache_nru_top.sv =====
// Top level: set-associative cache tag lookup with NRU replacement
// Flow: after the input transfer come set-index reduction (reciprocal multiply, then
//   subtract), a memory read and the row update, which registers the result.
// A new address is taken only once the read-modify-write of the previous set row is done;
//   a result left waiting at the output holds the row update until it is taken.
// Reset: rst clears control and config; a clearing pass then rewrites every set row
//   (no address accepted meanwhile, config writes still taken).
`default_nettype none
module set_assoc_cache_nru_top import sac_nru_pkg::*; #(
  parameter int unsigned MAX_SETS   = 1024,
  parameter int unsigned MAX_WAYS   = 8,
  parameter int unsigned ADDR_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  sac_nru_in_if.sink                 in_ch,
  sac_nru_out_if.source              out_ch
);

  localparam int unsigned TAG_W  = ADDR_WIDTH;
  localparam int unsigned SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int unsigned WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned ROW_W  = MAX_WAYS * (TAG_W + 2);
  localparam int unsigned VLD_LO = MAX_WAYS * TAG_W;
  localparam int unsigned REC_LO = MAX_WAYS * (TAG_W + 1);
  localparam int unsigned DIV_SH = IDX_W + ((MAX_SETS > 1) ? $clog2(MAX_SETS) : 0);
  localparam int unsigned RCP_W  = IDX_W + 2;
  localparam int unsigned PROD_W = IDX_W + RCP_W;
  localparam longint unsigned RCP_VAL =
    ((64'd1 << DIV_SH) + 64'(MAX_SETS) - 64'd1) / 64'(MAX_SETS);
  localparam logic [RCP_W-1:0]  RCP        = RCP_W'(RCP_VAL);
  localparam logic [STEP_W-1:0] FIRST_STEP = STEP_W'(1);
  localparam logic [SET_W-1:0]  LAST_SET   = SET_W'(MAX_SETS - 1);
  localparam logic [NW_W-1:0]   NWAYS_MAX  = NW_W'(MAX_WAYS);

  // configuration
  logic [AB_W-1:0] addr_len;
  logic [OB_W-1:0] ofs_len;
  logic [IB_W-1:0] idx_len;
  logic [WU_W-1:0] ways_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      addr_len    <= AB_RESET;
      ofs_len     <= OB_RESET;
      idx_len     <= IB_RESET;
      ways_in_use <= WU_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_ADDR_LEN:    addr_len    <= cfg_data[AB_W-1:0];
        CFG_OFS_LEN:     ofs_len     <= cfg_data[OB_W-1:0];
        CFG_IDX_LEN:     idx_len     <= cfg_data[IB_W-1:0];
        CFG_WAYS_IN_USE: ways_in_use <= cfg_data[WU_W-1:0];
        default: ;
      endcase
    end
  end

  // control
  state_t state, state_next;
  logic   in_ready;
  logic   in_xfer;
  logic   upd_fire;
  logic   ram_we;
  logic   ram_re;

  logic [REM_W-1:0]  rem;
  logic [IDX_W-1:0]  quo;
  logic [STEP_W-1:0] step;
  logic [TAG_W-1:0]  tag_q;
  logic [SET_W-1:0]  clr_addr;
  logic [MISS_W-1:0] misses;

  logic                 out_valid;
  logic                 out_hit;
  logic [WAY_OUT_W-1:0] out_way;
  logic [MISS_W-1:0]    out_miss;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    upd_fire   = 1'b0;
    ram_re     = 1'b0;
    case (state)
      S_CLEAR: begin
        if (clr_addr == LAST_SET) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          state_next = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (step == '0) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        ram_re     = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        if (!out_valid || out_ch.ready) begin
          upd_fire   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  assign in_xfer = in_ready && in_ch.valid;
  assign ram_we  = (state == S_CLEAR) || upd_fire;

  // address split
  logic [ADDR_WIDTH-1:0] addr_masked;
  logic [ADDR_WIDTH-1:0] addr_shifted;
  logic [IDX_W-1:0]      idx_raw;
  logic [IDX_W-1:0]      idx_mask;
  logic [TAG_W-1:0]      tag_val;

  always_comb begin
    addr_masked  = in_ch.address & ~({ADDR_WIDTH{1'b1}} << addr_len);
    addr_shifted = addr_masked >> ofs_len;
    idx_raw      = IDX_W'({{IDX_W{1'b0}}, addr_shifted});
    idx_mask     = IDX_W'((32'd1 << idx_len) - 32'd1);
    tag_val      = addr_masked >> (SH_W'(ofs_len) + SH_W'(idx_len));
  end

  // set index modulo MAX_SETS: quotient by reciprocal multiply, then one subtract
  logic [PROD_W-1:0] prod;
  logic [REM_W-1:0]  quo_mul;

  assign prod    = PROD_W'(rem[IDX_W-1:0]) * PROD_W'(RCP);
  assign quo_mul = REM_W'(32'(quo) * 32'(MAX_SETS));

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rem   <= REM_W'(idx_raw & idx_mask);
      step  <= FIRST_STEP;
      tag_q <= tag_val;
    end else if (state == S_REDUCE) begin
      if (step != '0) begin
        quo <= IDX_W'(prod >> DIV_SH);
      end else begin
        rem <= rem - quo_mul;
      end
      step <= step - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == S_CLEAR) begin
      clr_addr <= clr_addr + SET_W'(1);
    end
  end

  // set row memory: {recent, valid, tags}
  logic [ROW_W-1:0] rd_row;
  logic [ROW_W-1:0] wr_row;
  logic [SET_W-1:0] set_q;

  assign set_q = rem[SET_W-1:0];

  sac_nru_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_SETS)
  ) u_set_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr ((state == S_CLEAR) ? clr_addr : set_q),
    .wdata (wr_row),
    .re    (ram_re),
    .raddr (set_q),
    .rdata (rd_row)
  );

  // lookup and replacement
  logic [NW_W-1:0]     nways;
  logic [MAX_WAYS-1:0] in_use;
  logic [TAG_W-1:0]    rd_tag [MAX_WAYS];
  logic [MAX_WAYS-1:0] rd_valid;
  logic [MAX_WAYS-1:0] rd_recent;
  logic [MAX_WAYS-1:0] hit_vec;
  logic [MAX_WAYS-1:0] rec_vec;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    rec_way;
  logic [WAY_W-1:0]    chosen;
  logic                found;
  logic [MAX_WAYS-1:0] new_valid;
  logic [MAX_WAYS-1:0] new_recent;

  always_comb begin
    if (ways_in_use == '0) begin
      nways = NW_W'(1);
    end else if (NW_W'(ways_in_use) > NWAYS_MAX) begin
      nways = NWAYS_MAX;
    end else begin
      nways = NW_W'(ways_in_use);
    end

    rd_valid  = rd_row[VLD_LO +: MAX_WAYS];
    rd_recent = rd_row[REC_LO +: MAX_WAYS];
    for (int w = 0; w < MAX_WAYS; w++) begin
      rd_tag[w]  = rd_row[w*TAG_W +: TAG_W];
      in_use[w]  = NW_W'(w) < nways;
      hit_vec[w] = in_use[w] && rd_valid[w] && (rd_tag[w] == tag_q);
      rec_vec[w] = in_use[w] && rd_recent[w];
    end

    hit_way = '0;
    rec_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
      if (rec_vec[w]) begin
        rec_way = WAY_W'(w);
      end
    end

    found      = |hit_vec;
    new_valid  = rd_valid;
    new_recent = rd_recent;
    if (found) begin
      chosen = hit_way;
    end else if (|rec_vec) begin
      chosen = rec_way;
    end else begin
      chosen     = '0;
      new_recent = rd_recent | in_use;
    end
    new_recent[chosen] = 1'b0;
    if (!found) begin
      new_valid[chosen] = 1'b1;
    end

    if (state == S_CLEAR) begin
      wr_row = {{MAX_WAYS{1'b1}}, {MAX_WAYS{1'b0}}, {VLD_LO{1'b0}}};
    end else begin
      wr_row                     = rd_row;
      wr_row[VLD_LO +: MAX_WAYS] = new_valid;
      wr_row[REC_LO +: MAX_WAYS] = new_recent;
      if (!found) begin
        wr_row[chosen*TAG_W +: TAG_W] = tag_q;
      end
    end
  end

  // miss count and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      misses    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (upd_fire) begin
        out_valid <= 1'b1;
        if (!found) begin
          misses <= misses + MISS_W'(1);
        end
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      out_hit  <= found;
      out_way  <= WAY_OUT_W'(chosen);
      out_miss <= found ? misses : misses + MISS_W'(1);
    end
  end

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid;
  assign out_ch.hit           = out_hit;
  assign out_ch.way           = out_way;
  assign out_ch.misses_so_far = out_miss;

endmodule
`default_nettype wire

// ===== sv/sac_nru_chk.sv =====
// Checker: port-level assertions for the top level, attached by bind
`default_nettype none
`include "set_assoc_cache_nru_top_defines.svh"
module sac_nru_chk import sac_nru_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic                 hit,
  input wire logic [WAY_OUT_W-1:0] way,
  input wire logic [MISS_W-1:0]    misses_so_far
);

  `SAC_NRU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(hit) && $stable(way) && $stable(misses_so_far), "result changed while stalled")
  `SAC_NRU_ASSERT_SAME(a_clear_after_rst, $past(rst), !in_ready && !out_valid, "not clearing after reset")
  `SAC_NRU_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "second address taken while busy")
  `SAC_NRU_ASSERT_SAME(a_result_from_lookup, $rose(out_valid), $past(!in_ready), "result without a lookup")

endmodule

bind set_assoc_cache_nru_top sac_nru_chk u_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .hit           (out_ch.hit),
  .way           (out_ch.way),
  .misses_so_far (out_ch.misses_so_far)
);
`default_nettype wire

// ===== test/tb.sv =====
// Testbench for the set-associative cache tag block with NRU replacement
`timescale 1ns / 1ps
module tb import sac_nru_pkg::*;;

  localparam int unsigned N_SETS      = 1024;
  localparam int unsigned N_WAYS      = 8;
  localparam int unsigned A_W         = 32;
  localparam int unsigned SETTLE      = 20;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic                 hit;
    logic [WAY_OUT_W-1:0] way;
    logic [MISS_W-1:0]    misses;
  } lookup_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sac_nru_in_if #(.ADDR_WIDTH(A_W)) in_ch ();
  sac_nru_out_if out_ch ();

  set_assoc_cache_nru_top #(
    .MAX_SETS  (N_SETS),
    .MAX_WAYS  (N_WAYS),
    .ADDR_WIDTH(A_W)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // shadow of the tag array and its registers
  bit [31:0]   tag_mem [N_SETS][N_WAYS];
  bit          valid_mem [N_SETS][N_WAYS];
  bit          nru_mem [N_SETS][N_WAYS];
  bit [31:0]   miss_count;
  bit [AB_W-1:0] cur_ab;
  bit [OB_W-1:0] cur_ob;
  bit [IB_W-1:0] cur_ib;
  bit [WU_W-1:0] cur_wu;

  bit [31:0]       pending_addresses[$];
  lookup_t         expected_lookups[$];
  lookup_t         want;
  int              outstanding;
  int              n_errors;
  int unsigned     cycles;
  int unsigned     tx_wait;
  int unsigned     rx_wait;
  bit              tx_calm;
  bit              rx_calm;
  int unsigned     tag_span;
  longint unsigned set_pool[4];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned ways_effective();
    if (cur_wu == 0) return 1;
    if (cur_wu > N_WAYS) return N_WAYS;
    return 32'(cur_wu);
  endfunction

  function automatic lookup_t predict_lookup(bit [31:0] address);
    int unsigned     ab, ob, ib, nways, set_no, chosen;
    longint unsigned addr, idx, tag;
    bit              found, any;
    lookup_t         r;
    ab = (cur_ab > A_W) ? A_W : 32'(cur_ab);
    ob = 32'(cur_ob);
    ib = 32'(cur_ib);
    addr = longint'(address) & ((64'd1 << ab) - 1);
    idx = (addr >> ob) & ((64'd1 << ib) - 1);
    tag = addr >> (ob + ib);
    set_no = 32'(idx % N_SETS);
    nways = ways_effective();
    found = 1'b0;
    chosen = 0;
    for (int w = 0; w < nways; w++) begin
      if (!found && valid_mem[set_no][w] && tag_mem[set_no][w] == tag[31:0]) begin
        found = 1'b1;
        chosen = w;
      end
    end
    if (found) begin
      nru_mem[set_no][chosen] = 1'b0;
    end else begin
      miss_count++;
      any = 1'b0;
      for (int w = 0; w < nways; w++) begin
        if (!any && nru_mem[set_no][w]) begin
          any = 1'b1;
          chosen = w;
        end
      end
      if (!any) begin
        for (int w = 0; w < nways; w++) nru_mem[set_no][w] = 1'b1;
        chosen = 0;
      end
      tag_mem[set_no][chosen] = tag[31:0];
      valid_mem[set_no][chosen] = 1'b1;
      nru_mem[set_no][chosen] = 1'b0;
    end
    r.hit = found;
    r.way = chosen[WAY_OUT_W-1:0];
    r.misses = miss_count;
    return r;
  endfunction

  // mostly a few tags over a few sets so hits and evictions happen
  function automatic bit [31:0] pick_address();
    int unsigned     ab, ob, ib;
    longint unsigned a, tagv, setv, low_mask;
    ab = (cur_ab > A_W) ? A_W : 32'(cur_ab);
    ob = 32'(cur_ob);
    ib = 32'(cur_ib);
    if ($urandom_range(0, 9) < 3) return $urandom;
    tagv = $urandom_range(0, tag_span);
    if ($urandom_range(0, 15) == 0) tagv = {$urandom, $urandom};
    setv = set_pool[$urandom_range(0, 3)];
    low_mask = (64'd1 << ab) - 1;
    a = (tagv << (ob + ib)) | (setv << ob) | (longint'($urandom) & ((64'd1 << ob) - 1));
    a &= low_mask;
    if ($urandom_range(0, 3) == 0) a |= longint'($urandom) & ~low_mask;
    return a[31:0];
  endfunction

  task automatic send(bit [31:0] address);
    pending_addresses.push_back(address);
    outstanding++;
  endtask

  task automatic write_reg(cfg_reg_t r, bit [CFG_DATA_W-1:0] d);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= d;
    case (r)
      CFG_ADDR_LEN:    cur_ab = d[AB_W-1:0];
      CFG_OFS_LEN:     cur_ob = d[OB_W-1:0];
      CFG_IDX_LEN:     cur_ib = d[IB_W-1:0];
      CFG_WAYS_IN_USE: cur_wu = d[WU_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drain();
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_phase(bit [5:0] ab, bit [5:0] ob, bit [5:0] ib, bit [5:0] wu, int n);
    write_reg(CFG_ADDR_LEN, ab);
    write_reg(CFG_OFS_LEN, ob);
    write_reg(CFG_IDX_LEN, ib);
    write_reg(CFG_WAYS_IN_USE, wu);
    tag_span = ways_effective() + 2;
    for (int k = 0; k < 4; k++) set_pool[k] = longint'($urandom) & ((64'd1 << cur_ib) - 1);
    tx_calm = ($urandom_range(0, 3) == 0);
    rx_calm = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < n; k++) send(pick_address());
    wait_drain();
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      tx_wait = 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) expected_lookups.push_back(predict_lookup(in_ch.address));
      if (tx_wait > 0) begin
        tx_wait--;
        in_ch.valid <= 1'b0;
      end else if (pending_addresses.size() > 0) begin
        in_ch.address <= pending_addresses.pop_front();
        in_ch.valid   <= 1'b1;
        tx_wait = tx_calm ? 0 : $urandom_range(0, 6);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_lookups.size() == 0) begin
          $display("%0t unexpected transfer: hit %0d way %0d misses %0d", $time,
                   out_ch.hit, out_ch.way, out_ch.misses_so_far);
          n_errors++;
        end else begin
          want = expected_lookups.pop_front();
          outstanding--;
          if (out_ch.hit !== want.hit) begin
            $display("%0t hit mismatch: expected %0d actual %0d", $time, want.hit, out_ch.hit);
            n_errors++;
          end
          if (out_ch.way !== want.way) begin
            $display("%0t way mismatch: expected %0d actual %0d", $time, want.way, out_ch.way);
            n_errors++;
          end
          if (out_ch.misses_so_far !== want.misses) begin
            $display("%0t misses_so_far mismatch: expected %0d actual %0d", $time,
                     want.misses, out_ch.misses_so_far);
            n_errors++;
          end
        end
        rx_wait = rx_calm ? 0 : $urandom_range(0, 6);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = CFG_ADDR_LEN;
    cfg_data      = '0;
    n_errors      = 0;
    outstanding   = 0;
    miss_count    = 0;
    tx_calm       = 1'b0;
    rx_calm       = 1'b0;
    for (int s = 0; s < N_SETS; s++) begin
      for (int w = 0; w < N_WAYS; w++) begin
        valid_mem[s][w] = 1'b0;
        nru_mem[s][w]   = 1'b1;
      end
    end
    cur_ab = AB_RESET;
    cur_ob = OB_RESET;
    cur_ib = IB_RESET;
    cur_wu = WU_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset geometry: fill set 0, evict after all marks clear, hit after reset of marks
    send(32'h0000_0000);
    send(32'hFFFF_FFFF);
    for (int t = 1; t < 8; t++) send(t << 14);
    send(32'h0000_000F);
    send(32'd8 << 14);
    send(32'd1 << 14);
    send(32'h0000_0000);
    send(32'hFFFF_FFF0);
    send(32'h0000_3FF0);
    wait_drain();

    run_phase(6'd32, 6'd0, 6'd0, 6'd1, 80);
    run_phase(6'd1, 6'd0, 6'd0, 6'd8, 60);
    run_phase(6'd63, 6'd31, 6'd15, 6'd15, 80);
    run_phase(6'd20, 6'd3, 6'd15, 6'd0, 80);
    run_phase(6'd12, 6'd2, 6'd10, 6'd4, 80);
    run_phase(6'd8, 6'd4, 6'd4, 6'd8, 80);
    run_phase(6'd32, 6'd31, 6'd0, 6'd2, 60);
    run_phase(6'd32, 6'd4, 6'd10, 6'd9, 100);
    run_phase(6'd32, 6'd0, 6'd2, 6'd3, 100);
    for (int p = 0; p < 10; p++) begin
      run_phase(6'($urandom), 6'($urandom), 6'($urandom), 6'($urandom), 70);
    end
    wait_drain();

    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/sac_nru_pkg.sv
sv/sac_nru_in_if.sv
sv/sac_nru_out_if.sv
sv/sac_nru_ram.sv
sv/set_assoc_cache_nru_top.sv
sv/sac_nru_chk.sv
test/tb.sv
